// ===== sv/bass_pkg.sv =====
// ----------------------------------------------------------------------------
// bass_pkg: shared types and constants for the bracket aware sentence splitter
// Holds the bracket pair and break mark code points, the classified item that
// travels from the front end to the back end, and the classification helpers.
// ----------------------------------------------------------------------------
package bass_pkg;

  localparam int unsigned UNIT_W = 16;
  localparam int unsigned LEN_W = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd128;

  // Bracket and quote pairs.
  localparam logic [UNIT_W-1:0] OPEN_FW_PAREN   = 16'hFF08;
  localparam logic [UNIT_W-1:0] CLOSE_FW_PAREN  = 16'hFF09;
  localparam logic [UNIT_W-1:0] OPEN_PAREN      = 16'h0028;
  localparam logic [UNIT_W-1:0] CLOSE_PAREN     = 16'h0029;
  localparam logic [UNIT_W-1:0] OPEN_SQUARE     = 16'h005B;
  localparam logic [UNIT_W-1:0] CLOSE_SQUARE    = 16'h005D;
  localparam logic [UNIT_W-1:0] OPEN_LENTICULAR = 16'h3010;
  localparam logic [UNIT_W-1:0] CLOSE_LENTICULAR = 16'h3011;
  localparam logic [UNIT_W-1:0] OPEN_DBL_ANGLE  = 16'h300A;
  localparam logic [UNIT_W-1:0] CLOSE_DBL_ANGLE = 16'h300B;
  localparam logic [UNIT_W-1:0] OPEN_DBL_QUOTE  = 16'h201C;
  localparam logic [UNIT_W-1:0] CLOSE_DBL_QUOTE = 16'h201D;

  // Break marks.
  localparam logic [UNIT_W-1:0] BRK_IDEO_STOP   = 16'h3002;
  localparam logic [UNIT_W-1:0] BRK_COMMA       = 16'h002C;
  localparam logic [UNIT_W-1:0] BRK_FW_COMMA    = 16'hFF0C;
  localparam logic [UNIT_W-1:0] BRK_SPACE       = 16'h0020;
  localparam logic [UNIT_W-1:0] BRK_TAB         = 16'h0009;
  localparam logic [UNIT_W-1:0] BRK_QUESTION    = 16'h003F;
  localparam logic [UNIT_W-1:0] BRK_FW_QUESTION = 16'hFF1F;
  localparam logic [UNIT_W-1:0] BRK_EXCLAIM     = 16'h0021;
  localparam logic [UNIT_W-1:0] BRK_FW_EXCLAIM  = 16'hFF01;
  localparam logic [UNIT_W-1:0] BRK_SEMICOLON   = 16'h003B;
  localparam logic [UNIT_W-1:0] BRK_FW_SEMI     = 16'hFF1B;

  localparam logic [UNIT_W-1:0] NO_CLOSER = '0;

  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic              last;
    logic              is_pair;
    logic              is_brk;
    logic [UNIT_W-1:0] partner;
  } bass_item_t;

  function automatic logic is_pair_mark(logic [UNIT_W-1:0] u);
    logic hit;
    case (u) inside
      OPEN_FW_PAREN, CLOSE_FW_PAREN, OPEN_PAREN, CLOSE_PAREN,
      OPEN_SQUARE, CLOSE_SQUARE, OPEN_LENTICULAR, CLOSE_LENTICULAR,
      OPEN_DBL_ANGLE, CLOSE_DBL_ANGLE, OPEN_DBL_QUOTE, CLOSE_DBL_QUOTE: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // Closer that an opener arms; closers and other units give no closer.
  function automatic logic [UNIT_W-1:0] pair_partner(logic [UNIT_W-1:0] u);
    logic [UNIT_W-1:0] p;
    case (u)
      OPEN_FW_PAREN:   p = CLOSE_FW_PAREN;
      OPEN_PAREN:      p = CLOSE_PAREN;
      OPEN_SQUARE:     p = CLOSE_SQUARE;
      OPEN_LENTICULAR: p = CLOSE_LENTICULAR;
      OPEN_DBL_ANGLE:  p = CLOSE_DBL_ANGLE;
      OPEN_DBL_QUOTE:  p = CLOSE_DBL_QUOTE;
      default:         p = NO_CLOSER;
    endcase
    return p;
  endfunction

  function automatic logic is_stop_mark(logic [UNIT_W-1:0] u);
    logic hit;
    case (u) inside
      BRK_IDEO_STOP, BRK_COMMA, BRK_FW_COMMA, BRK_SPACE, BRK_TAB, BRK_QUESTION,
      BRK_FW_QUESTION, BRK_EXCLAIM, BRK_FW_EXCLAIM, BRK_SEMICOLON,
      BRK_FW_SEMI: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ===== sv/bass_front.sv =====
// ----------------------------------------------------------------------------
// bass_front: input side of the splitter
// Accepts code units and classifies each one before it enters the queue.
// ----------------------------------------------------------------------------
module bass_front (
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [bass_pkg::UNIT_W-1:0] code_unit_i,
  input  logic                     last_i,
  input  logic                     q_full_i,
  output logic                     q_push_o,
  output bass_pkg::bass_item_t     q_item_o
);
  import bass_pkg::*;

  assign in_ready_o = ~q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

  always_comb begin
    q_item_o.unit    = code_unit_i;
    q_item_o.last    = last_i;
    q_item_o.is_pair = is_pair_mark(code_unit_i);
    q_item_o.is_brk  = is_stop_mark(code_unit_i);
    q_item_o.partner = pair_partner(code_unit_i);
  end

endmodule

// ===== sv/bass_queue.sv =====
// ----------------------------------------------------------------------------
// bass_queue: small FIFO between front end and back end
// Holds classified items so that each side can stall on its own.
// ----------------------------------------------------------------------------
module bass_queue #(
  parameter int unsigned Depth = bass_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  bass_pkg::bass_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output bass_pkg::bass_item_t item_o
);
  import bass_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bass_item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== sv/bass_back.sv =====
// ----------------------------------------------------------------------------
// bass_back: segmentation state and output register
// Applies one classified item per cycle to the bracket and length state while
// its output is free and holds the result until the consumer takes it.
// ----------------------------------------------------------------------------
module bass_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bass_pkg::LEN_W-1:0]  cfg_wdata_i,
  input  logic                        q_valid_i,
  input  bass_pkg::bass_item_t        q_item_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bass_pkg::UNIT_W-1:0] unit_out_o,
  output logic                        cut_before_o,
  output logic                        cut_after_o
);
  import bass_pkg::*;

  logic [LEN_W-1:0]  max_len_q;
  logic [UNIT_W-1:0] closer_q, closer_d;
  logic [LEN_W-1:0]  count_q, count_d;
  logic              out_valid_q, out_valid_d;
  logic [UNIT_W-1:0] unit_q;
  logic              cb_q, cb_d;
  logic              ca_q, ca_d;

  logic [LEN_W:0]    len_kept;
  logic              len_hit;
  logic [LEN_W-1:0]  len_sat;
  logic              take;

  assign take     = q_valid_i & (~out_valid_q | out_ready_i);
  assign q_pop_o  = take;
  assign len_kept = {1'b0, count_q} + (LEN_W+1)'(1);
  assign len_hit  = (len_kept >= {1'b0, max_len_q});
  assign len_sat  = len_kept[LEN_W] ? '1 : len_kept[LEN_W-1:0];

  always_comb begin
    closer_d = closer_q;
    count_d  = count_q;
    cb_d     = 1'b0;
    ca_d     = 1'b0;
    if (q_item_i.is_pair) begin
      if (closer_q == q_item_i.unit) begin
        ca_d     = 1'b1;
        count_d  = '0;
        closer_d = NO_CLOSER;
      end else begin
        cb_d     = (count_q != '0);
        count_d  = LEN_W'(1);
        closer_d = q_item_i.partner;
      end
    end else if (closer_q == NO_CLOSER) begin
      if (q_item_i.is_brk || len_hit) begin
        ca_d    = 1'b1;
        count_d = '0;
      end else begin
        count_d = len_sat;
      end
    end else if (len_hit) begin
      ca_d     = 1'b1;
      count_d  = '0;
      closer_d = NO_CLOSER;
    end else begin
      count_d = len_sat;
    end
    if (q_item_i.last) begin
      ca_d     = 1'b1;
      count_d  = '0;
      closer_d = NO_CLOSER;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q   <= MAX_LEN_RESET;
      closer_q    <= NO_CLOSER;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      if (take) begin
        closer_q <= closer_d;
        count_q  <= count_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      unit_q <= q_item_i.unit;
      cb_q   <= cb_d;
      ca_q   <= ca_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign unit_out_o   = unit_q;
  assign cut_before_o = cb_q;
  assign cut_after_o  = ca_q;

endmodule

// ===== sv/bracket_aware_sentence_splitter.sv =====
// ----------------------------------------------------------------------------
// bracket_aware_sentence_splitter: marks segment boundaries in UTF-16 text
// Top level joining the classifying front end, the item queue and the
// segmentation back end.
// ----------------------------------------------------------------------------
// The splitter takes one UTF-16 code unit per request and returns one result
// per unit: the unit itself with a cut_before flag (a segment ends just before
// it) and a cut_after flag (a segment ends with it). Six bracket and quote
// pairs are recognized; an opener starts a new segment and arms its closer,
// the matching closer ends the segment, and a stray closer starts a fresh
// segment. Outside brackets the break marks end a segment, and any segment is
// cut once its length reaches max_segment_length (reset value 128). It is
// written through cfg_we_i and cfg_wdata_i; the user must write it only while
// no text is in flight; the block itself does not enforce this. The unit
// flagged last always ends a segment and returns the block to its idle state.
// The block sustains one code unit per clock cycle while the output is not
// stalled. An accepted unit is written into the queue between front and back
// end, and the back end then takes it through its state update into the
// output register, which is the step that sets the rate. The queue holds
// QueueDepth units, so the input keeps accepting while the output is briefly
// stalled.
module bracket_aware_sentence_splitter #(
  parameter int unsigned QueueDepth = bass_pkg::QUEUE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bass_pkg::LEN_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bass_pkg::UNIT_W-1:0] code_unit_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bass_pkg::UNIT_W-1:0] unit_out_o,
  output logic                        cut_before_o,
  output logic                        cut_after_o
);
  import bass_pkg::*;

  // Classified items flow from the front end into the queue.
  logic       q_push;
  logic       q_full;
  bass_item_t q_in_item;

  // The back end pops one item whenever its output register is free.
  logic       q_pop;
  logic       q_valid;
  bass_item_t q_out_item;

  bass_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .code_unit_i (code_unit_i),
    .last_i      (last_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (q_in_item)
  );

  bass_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out_item)
  );

  // The back end owns the length register, the expected closer and the
  // running segment length; it also holds the result until it is taken.
  bass_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .q_valid_i    (q_valid),
    .q_item_i     (q_out_item),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .unit_out_o   (unit_out_o),
    .cut_before_o (cut_before_o),
    .cut_after_o  (cut_after_o)
  );

endmodule

// ===== sv/bass_checker.sv =====
// ----------------------------------------------------------------------------
// bass_checker: port level checks for the sentence splitter
// Watches the top level ports and flags output and flow control slips.
// ----------------------------------------------------------------------------
module bass_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [bass_pkg::UNIT_W-1:0] unit_out_o,
  input logic                        cut_before_o,
  input logic                        cut_after_o
);
  import bass_pkg::*;

  // A stalled result keeps its valid and payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(unit_out_o) && $stable(cut_before_o) && $stable(cut_after_o))
    else $error("stalled result changed");

  // Only a bracket or quote mark can end a segment before itself.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cut_before_o |-> is_pair_mark(unit_out_o))
    else $error("cut before a unit that is not a pair mark");

  // The queue fills only while a result waits on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // Nothing reaches the output in the first cycle after reset.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result shown right after reset");

endmodule

bind bracket_aware_sentence_splitter bass_checker u_bass_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .unit_out_o   (unit_out_o),
  .cut_before_o (cut_before_o),
  .cut_after_o  (cut_after_o)
);
